[design/aope_pkg.sv]
// Shared types and constants for the info age and prediction error block.
package aope_pkg;

   localparam int DATA_W     = 32;
   localparam int VEL_W      = 24;
   localparam int ACC_IN_W   = 17;
   localparam int MUL_A_W    = 34;
   localparam int PROD_W     = 66;
   localparam int ACC_W      = 84;
   localparam int REM_W      = 21;
   localparam int ROOT_STEPS = 32;
   localparam int CNT_W      = 6;
   localparam int REQ_DATA_W = 184;
   localparam int RSP_DATA_W = 96;

   // scale 2000000 = 2^7 * 15625; the odd part goes through a reciprocal multiply
   localparam int DEN_SHIFT = 7;
   localparam int DEN_N_W   = 46;
   localparam int RCP_SHIFT = 20;

   localparam logic [REM_W-1:0]   POS_SCALE  = 21'd2000000;
   localparam logic [DATA_W-1:0]  SAT_VAL    = 32'hFFFF_FFFF;
   localparam logic [ACC_W-1:0]   HALF_SCALE = 84'd1000000;
   // smallest magnitude whose rounded quotient reaches 2^32
   localparam logic [ACC_W-1:0]   SAT_LIM    = 84'd8589934591000000;
   // floor(2^45 / 15625)
   localparam logic [DATA_W-1:0]  RECIP      = 32'd2251799813;
   localparam logic [DATA_W-1:0]  DEN_ODD    = 32'd15625;
   localparam logic [DEN_N_W-1:0] DEN_X1     = 46'd15625;
   localparam logic [DEN_N_W-1:0] DEN_X2     = 46'd31250;
   localparam logic [DEN_N_W-1:0] DEN_X3     = 46'd46875;

   typedef enum logic {
      OP_MESSAGE = 1'b0,
      OP_SAMPLE  = 1'b1
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE, S_TT, S_D, S_VT, S_ALO, S_AHI, S_SUBHI, S_SUBVT, S_MAG, S_HALF,
      S_RCP, S_QEST, S_RND, S_SQX, S_SQY, S_SQS, S_RINIT, S_ROOT, S_DONE
   } state_type;

   typedef enum logic [3:0] {
      MUL_TT, MUL_D, MUL_VT, MUL_ALO, MUL_AHI, MUL_RCP, MUL_QS, MUL_SQX, MUL_SQY
   } mul_sel_type;

   typedef enum logic [3:0] {
      DP_NONE, DP_TT, DP_ACC_LD, DP_VT, DP_ACC_SUB, DP_ACC_SUBHI, DP_ACC_SUBVT,
      DP_DIV_INIT, DP_DIV_HALF, DP_QEST, DP_ROUND, DP_SUM_LD, DP_SUM_ADD,
      DP_ROOT_INIT, DP_ROOT_STEP, DP_OUT
   } dp_op_type;

   typedef struct packed {
      logic        load;
      mul_sel_type mul_sel;
      dp_op_type   dp_op;
      logic        axis;
   } cmd_type;

   typedef struct packed {
      logic have_msg;
      logic out_free;
   } status_type;

endpackage

[design/aope_ctrl.sv]
// Controller: sequences the shared multiplier, divider and square root steps.
module aope_ctrl
   import aope_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tuser,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             axis_ff, axis_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         axis_ff  <= axis_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      axis_in     = axis_ff;
      req_tready  = 1'b0;
      cmd.load    = 1'b0;
      cmd.mul_sel = MUL_TT;
      cmd.dp_op   = DP_NONE;
      cmd.axis    = axis_ff;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            axis_in    = 1'b0;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_tuser == OP_SAMPLE && status.have_msg) begin
                  state_in = S_TT;
               end
            end
         end
         S_TT: begin
            cmd.mul_sel = MUL_TT;
            state_in    = S_D;
         end
         S_D: begin
            cmd.mul_sel = MUL_D;
            // second axis reuses t*t already captured
            cmd.dp_op   = axis_ff ? DP_NONE : DP_TT;
            state_in    = S_VT;
         end
         S_VT: begin
            cmd.mul_sel = MUL_VT;
            cmd.dp_op   = DP_ACC_LD;
            state_in    = S_ALO;
         end
         S_ALO: begin
            cmd.mul_sel = MUL_ALO;
            cmd.dp_op   = DP_VT;
            state_in    = S_AHI;
         end
         S_AHI: begin
            cmd.mul_sel = MUL_AHI;
            cmd.dp_op   = DP_ACC_SUB;
            state_in    = S_SUBHI;
         end
         S_SUBHI: begin
            cmd.dp_op = DP_ACC_SUBHI;
            state_in  = S_SUBVT;
         end
         S_SUBVT: begin
            cmd.dp_op = DP_ACC_SUBVT;
            state_in  = S_MAG;
         end
         S_MAG: begin
            cmd.dp_op = DP_DIV_INIT;
            state_in  = S_HALF;
         end
         S_HALF: begin
            cmd.dp_op = DP_DIV_HALF;
            state_in  = S_RCP;
         end
         S_RCP: begin
            cmd.mul_sel = MUL_RCP;
            state_in    = S_QEST;
         end
         S_QEST: begin
            cmd.mul_sel = MUL_QS;
            cmd.dp_op   = DP_QEST;
            state_in    = S_RND;
         end
         S_RND: begin
            cmd.dp_op = DP_ROUND;
            if (axis_ff) begin
               state_in = S_SQX;
            end else begin
               axis_in  = 1'b1;
               state_in = S_D;
            end
         end
         S_SQX: begin
            cmd.mul_sel = MUL_SQX;
            state_in    = S_SQY;
         end
         S_SQY: begin
            cmd.mul_sel = MUL_SQY;
            cmd.dp_op   = DP_SUM_LD;
            state_in    = S_SQS;
         end
         S_SQS: begin
            cmd.dp_op = DP_SUM_ADD;
            state_in  = S_RINIT;
         end
         S_RINIT: begin
            cmd.dp_op = DP_ROOT_INIT;
            cnt_in    = '0;
            state_in  = S_ROOT;
         end
         S_ROOT: begin
            cmd.dp_op = DP_ROOT_STEP;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ROOT_STEPS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.dp_op = DP_OUT;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[design/aope_dp.sv]
// Datapath: stored message, shared multiplier, accumulator, divider, root, output register.
module aope_dp
   import aope_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic                       have_ff;
   logic [DATA_W-1:0]          sent_time_ff, sent_x_ff, sent_y_ff;
   logic signed [VEL_W-1:0]    sent_vx_ff, sent_vy_ff;
   logic signed [ACC_IN_W-1:0] sent_ax_ff, sent_ay_ff;
   logic [DATA_W-1:0]          tm_ff, age_ff, ex_ff, ey_ff;
   logic signed [DATA_W:0]     dx_ff, dy_ff;
   logic [2*DATA_W-1:0]        tt_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]    acc_ff, vt_ff;
   logic [DATA_W-1:0]          q_ff;
   logic                       sat_ff;
   logic [2*DATA_W:0]          sum_ff;
   logic [2*DATA_W-1:0]        n_ff, res_ff, bit_ff;
   logic                       rsp_valid_ff;
   logic [DATA_W-1:0]          out_time_ff, out_age_ff, out_err_ff;

   logic [DATA_W-1:0]          in_time, in_x, in_y;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic [DATA_W-1:0]          mul_b;
   logic signed [PROD_W:0]     prod_full;
   logic signed [ACC_W-1:0]    prod_ext;
   logic [DEN_N_W-1:0]         rem_fix;
   logic [1:0]                 q_adj;
   logic [DATA_W-1:0]          q_fix;
   logic [2*DATA_W-1:0]        root_try;

   assign in_time = req_tdata[31:0];
   assign in_x    = req_tdata[63:32];
   assign in_y    = req_tdata[95:64];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         MUL_TT: begin
            mul_a = MUL_A_W'(age_ff);
            mul_b = age_ff;
         end
         MUL_D: begin
            mul_a = cmd.axis ? MUL_A_W'(dy_ff) : MUL_A_W'(dx_ff);
            mul_b = DATA_W'(POS_SCALE);
         end
         MUL_VT: begin
            mul_a = cmd.axis ? MUL_A_W'(sent_vy_ff) : MUL_A_W'(sent_vx_ff);
            mul_b = age_ff;
         end
         MUL_ALO: begin
            mul_a = cmd.axis ? MUL_A_W'(sent_ay_ff) : MUL_A_W'(sent_ax_ff);
            mul_b = tt_ff[DATA_W-1:0];
         end
         MUL_AHI: begin
            mul_a = cmd.axis ? MUL_A_W'(sent_ay_ff) : MUL_A_W'(sent_ax_ff);
            mul_b = tt_ff[2*DATA_W-1:DATA_W];
         end
         MUL_RCP: begin
            mul_a = MUL_A_W'(acc_ff[RCP_SHIFT+DATA_W:RCP_SHIFT]);
            mul_b = RECIP;
         end
         MUL_QS: begin
            mul_a = MUL_A_W'(prod_ff[2*DATA_W-1:DATA_W]);
            mul_b = DEN_ODD;
         end
         MUL_SQX: begin
            mul_a = MUL_A_W'(ex_ff);
            mul_b = ex_ff;
         end
         MUL_SQY: begin
            mul_a = MUL_A_W'(ey_ff);
            mul_b = ey_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_full = mul_a * $signed({1'b0, mul_b});
   assign prod_ext  = ACC_W'(prod_ff);

   // reciprocal estimate is low by at most three; fix it from the remainder
   assign rem_fix = acc_ff[DEN_SHIFT+DEN_N_W-1:DEN_SHIFT] - prod_ff[DEN_N_W-1:0];

   always_comb begin
      if (rem_fix >= DEN_X3) begin
         q_adj = 2'd3;
      end else if (rem_fix >= DEN_X2) begin
         q_adj = 2'd2;
      end else if (rem_fix >= DEN_X1) begin
         q_adj = 2'd1;
      end else begin
         q_adj = 2'd0;
      end
   end

   assign q_fix    = q_ff + DATA_W'(q_adj);
   assign root_try = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff      <= 1'b0;
         sent_time_ff <= '0;
         sent_x_ff    <= '0;
         sent_y_ff    <= '0;
         sent_vx_ff   <= '0;
         sent_vy_ff   <= '0;
         sent_ax_ff   <= '0;
         sent_ay_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load && req_tuser == OP_MESSAGE) begin
            have_ff      <= 1'b1;
            sent_time_ff <= in_time;
            sent_x_ff    <= in_x;
            sent_y_ff    <= in_y;
            sent_vx_ff   <= req_tdata[119:96];
            sent_vy_ff   <= req_tdata[143:120];
            sent_ax_ff   <= req_tdata[160:144];
            sent_ay_ff   <= req_tdata[177:161];
         end
         if (cmd.dp_op == DP_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_full[PROD_W-1:0];
      if (cmd.load) begin
         tm_ff  <= in_time;
         age_ff <= (in_time >= sent_time_ff) ? in_time - sent_time_ff : '0;
         dx_ff  <= $signed({in_x[DATA_W-1], in_x}) - $signed({sent_x_ff[DATA_W-1], sent_x_ff});
         dy_ff  <= $signed({in_y[DATA_W-1], in_y}) - $signed({sent_y_ff[DATA_W-1], sent_y_ff});
         sat_ff <= 1'b0;
      end
      case (cmd.dp_op)
         DP_TT:        tt_ff  <= prod_ff[2*DATA_W-1:0];
         DP_ACC_LD:    acc_ff <= prod_ext;
         DP_VT:        vt_ff  <= (prod_ext <<< 11) - (prod_ext <<< 5) - (prod_ext <<< 4);
         DP_ACC_SUB:   acc_ff <= acc_ff - prod_ext;
         DP_ACC_SUBHI: acc_ff <= acc_ff - (prod_ext <<< DATA_W);
         DP_ACC_SUBVT: acc_ff <= acc_ff - vt_ff;
         DP_DIV_INIT:  acc_ff <= acc_ff[ACC_W-1] ? -acc_ff : acc_ff;
         DP_DIV_HALF: begin
            // adding half the scale turns the floor quotient into round half up
            acc_ff <= acc_ff + HALF_SCALE;
            sat_ff <= sat_ff | (acc_ff >= SAT_LIM);
         end
         DP_QEST:      q_ff   <= prod_ff[2*DATA_W-1:DATA_W];
         DP_ROUND: begin
            if (cmd.axis) begin
               ey_ff <= q_fix;
            end else begin
               ex_ff <= q_fix;
            end
         end
         DP_SUM_LD:    sum_ff <= {1'b0, prod_ff[2*DATA_W-1:0]};
         DP_SUM_ADD:   sum_ff <= sum_ff + {1'b0, prod_ff[2*DATA_W-1:0]};
         DP_ROOT_INIT: begin
            n_ff   <= sum_ff[2*DATA_W-1:0];
            res_ff <= '0;
            bit_ff <= {2'b01, {(2*DATA_W-2){1'b0}}};
         end
         DP_ROOT_STEP: begin
            if (n_ff >= root_try) begin
               n_ff   <= n_ff - root_try;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         DP_OUT: begin
            out_time_ff <= tm_ff;
            out_age_ff  <= age_ff;
            out_err_ff  <= (sat_ff || sum_ff[2*DATA_W]) ? SAT_VAL : res_ff[DATA_W-1:0];
         end
         default: ;
      endcase
   end

   assign status.have_msg = have_ff;
   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = {out_err_ff, out_age_ff, out_time_ff};

endmodule

[design/info_age_and_prediction_error.sv]
// Top level: age of information and dead-reckoning prediction error.
//
//   channel  dir  transfer payload
//   req_     in   tuser: operation; tdata: event_time, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y
//   rsp_     out  tdata: sample_time, info_age, position_error
//
// A message is stored and the block takes the next item in the next cycle. A sample
// with a stored message holds off the next item until its result is done: one shared
// 34x32 multiplier, division by the fixed scale as a reciprocal multiply with a small
// correction, one axis after the other, and a square root at one bit a cycle. A finished
// result waits in the output register; the block stalls only if that register is still
// full when the next result is done.
// Synchronous active-high reset clears the stored message.
module info_age_and_prediction_error
   import aope_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // event_time, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y
   input  logic                  req_tuser,  // operation
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // sample_time, info_age, position_error
);

   cmd_type    cmd;
   status_type status;

   aope_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   aope_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // a message never holds off the next transfer
   a_msg_fast: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == OP_MESSAGE |=> req_tready)
      else $error("ready dropped after message");

   // a result only appears at the end of a sample computation
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.dp_op == DP_OUT))
      else $error("result without completion");

   // age can never exceed the sample time
   a_age: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[63:32] <= rsp_tdata[31:0])
      else $error("info age larger than sample time");

endmodule
